>>> hdl/lfmc_pkg.sv
package lfmc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BASE_SPEED     = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN      = 3'd1;
  localparam logic [2:0] REG_RECOVERY_RATIO = 3'd2;
  localparam logic [2:0] REG_LOST_LIMIT     = 3'd3;
  localparam logic [2:0] REG_STRAIGHT_SPEED = 3'd4;
  localparam logic [2:0] REG_MAX_SPEED      = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  // Register reset values
  localparam logic [7:0] BASE_SPEED_RST     = 8'd120;
  localparam logic [7:0] PROP_GAIN_RST      = 8'd30;
  localparam logic [8:0] RECOVERY_RATIO_RST = 9'd205;
  localparam logic [5:0] LOST_LIMIT_RST     = 6'd25;
  localparam logic [7:0] STRAIGHT_SPEED_RST = 8'd150;
  localparam logic [7:0] MAX_SPEED_RST      = 8'd255;

  localparam logic [5:0] LOST_COUNT_MAX = 6'd63;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Divider: magnitude of gain * weight sum, two quotient bits per step
  localparam int DMAG_W    = 10;
  localparam int DIV_STEPS = DMAG_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Sensor weights by bit position: bit0 far right .. bit4 far left
  localparam logic signed [3:0] SENSOR_WEIGHT [5] = '{4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2};

  typedef enum logic [2:0] {
    MODE_TRACK         = 3'd0,
    MODE_RECOVER_LEFT  = 3'd1,
    MODE_RECOVER_RIGHT = 3'd2,
    MODE_LOST_BASE     = 3'd3,
    MODE_LOST_STRAIGHT = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    logic [7:0] base_speed;
    logic [7:0] prop_gain;
    logic [8:0] recovery_ratio_q8;
    logic [5:0] lost_limit;
    logic [7:0] straight_speed;
    logic [7:0] max_speed;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [2:0]        count;
    logic signed [3:0] sum;
  } cmd_t;

  typedef struct packed {
    logic [7:0] mag;
    logic       rev;
  } motor_t;

  // Clamp a signed speed to +/- lim and split it into magnitude and reverse flag
  function automatic motor_t encode_speed(logic signed [11:0] speed, logic [7:0] lim);
    logic signed [11:0] lim_s;
    logic signed [11:0] neg_s;
    motor_t             m;
    lim_s = $signed({4'b0, lim});
    neg_s = -speed;
    if (speed > lim_s) begin
      m.mag = lim;
      m.rev = 1'b0;
    end else if (speed < -lim_s) begin
      m.mag = lim;
      m.rev = (lim != 8'd0);
    end else if (speed < 12'sd0) begin
      m.mag = neg_s[7:0];
      m.rev = 1'b1;
    end else begin
      m.mag = speed[7:0];
      m.rev = 1'b0;
    end
    return m;
  endfunction

endpackage

>>> hdl/lfmc_channels.sv
interface lfmc_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink (input valid, input sensor_bits, output ready);
endinterface

interface lfmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_magnitude;
  logic       left_reverse;
  logic [7:0] right_magnitude;
  logic       right_reverse;
  logic [2:0] drive_mode;

  modport source (output valid, output left_magnitude, output left_reverse,
                  output right_magnitude, output right_reverse, output drive_mode,
                  input ready);
  modport sink (input valid, input left_magnitude, input left_reverse,
                input right_magnitude, input right_reverse, input drive_mode,
                output ready);
endinterface

interface lfmc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/lfmc_front.sv
module lfmc_front (
  input  logic          clk,
  input  logic          rst_n,
  lfmc_in_if.sink       in_bus,
  input  lfmc_pkg::cfg_t cfg,
  output logic          push_valid,
  input  logic          push_ready,
  output lfmc_pkg::cmd_t push_cmd
);
  import lfmc_pkg::*;

  logic       far_left_r, far_left_nxt;
  logic       far_right_r, far_right_nxt;
  logic [5:0] lost_r, lost_nxt;
  logic [5:0] lost_inc;
  logic       accept;
  logic [2:0] count;
  logic signed [3:0] sum;

  assign in_bus.ready = push_ready;
  assign push_valid   = in_bus.valid;
  assign accept       = in_bus.valid && push_ready;

  // Count active sensors and add up their weights
  always_comb begin
    count = 3'd0;
    sum   = 4'sd0;
    for (int b = 0; b < 5; b++) begin
      if (in_bus.sensor_bits[b]) begin
        count = count + 3'd1;
        sum   = sum + SENSOR_WEIGHT[b];
      end
    end
  end

  assign lost_inc = (lost_r < LOST_COUNT_MAX) ? lost_r + 6'd1 : lost_r;

  // Classify the beat and work out the next tracking memory
  always_comb begin
    far_left_nxt   = far_left_r;
    far_right_nxt  = far_right_r;
    lost_nxt       = lost_r;
    push_cmd.count = count;
    push_cmd.sum   = sum;
    if (in_bus.sensor_bits != 5'd0) begin
      push_cmd.mode = MODE_TRACK;
      lost_nxt      = 6'd0;
      far_left_nxt  = in_bus.sensor_bits[4];
      far_right_nxt = in_bus.sensor_bits[0];
    end else if (far_left_r) begin
      push_cmd.mode = MODE_RECOVER_LEFT;
    end else if (far_right_r) begin
      push_cmd.mode = MODE_RECOVER_RIGHT;
    end else begin
      lost_nxt = lost_inc;
      if (lost_inc >= cfg.lost_limit) begin
        push_cmd.mode = MODE_LOST_STRAIGHT;
      end else begin
        push_cmd.mode = MODE_LOST_BASE;
      end
    end
  end

  // Advance tracking memory on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_left_r  <= 1'b0;
      far_right_r <= 1'b0;
      lost_r      <= 6'd0;
    end else if (accept) begin
      far_left_r  <= far_left_nxt;
      far_right_r <= far_right_nxt;
      lost_r      <= lost_nxt;
    end
  end

endmodule

>>> hdl/lfmc_queue.sv
module lfmc_queue #(
  parameter int DEPTH = lfmc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  lfmc_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lfmc_pkg::cmd_t pop_cmd
);
  import lfmc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Wrap pointers and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/lfmc_back.sv
module lfmc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lfmc_pkg::cfg_t cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  lfmc_pkg::cmd_t pop_cmd,
  lfmc_out_if.source     out_bus
);
  import lfmc_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r;
  logic [DMAG_W-1:0]  quo_r, quo_nxt;
  logic [2:0]         rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r;
  logic               dneg_r;
  logic [16:0]        prod_r;
  logic               out_valid_r, out_valid_nxt;
  motor_t             left_r, right_r, left_nxt, right_nxt;
  mode_t              mode_r;

  logic ld_cmd, ld_mul, div_en, fin_load;

  logic [1:0]         sum_abs;
  logic [DMAG_W-1:0]  dmag;
  logic [4:0]         part, n1, n2, n3, part_left;
  logic [1:0]         digit;

  logic signed [11:0] trk_left, trk_right, rec_up, rec_down, spd_left, spd_right;
  logic signed [17:0] rec_diff;
  logic [17:0]        rec_mag;

  // Truncate base -/+ (q + r/n) toward zero
  function automatic logic signed [11:0] trunc_term(logic [7:0] base, logic [DMAG_W-1:0] q,
                                                    logic r_nz, logic sub);
    logic signed [11:0] lo;
    logic signed [11:0] res;
    lo = $signed({4'b0, base}) - $signed({2'b0, q});
    if (sub) begin
      res = (r_nz && lo > 12'sd0) ? lo - 12'sd1 : lo;
    end else begin
      res = $signed({4'b0, base}) + $signed({2'b0, q});
    end
    return res;
  endfunction

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (pop_valid) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = (cmd_r.mode == MODE_TRACK) ? BK_DIV : BK_FIN;
      BK_DIV:  if (step_r == STEP_LAST) state_nxt = BK_FIN;
      BK_FIN:  if (!out_valid_r || out_bus.ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    pop_ready = 1'b0;
    ld_cmd    = 1'b0;
    ld_mul    = 1'b0;
    div_en    = 1'b0;
    fin_load  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        ld_cmd    = pop_valid;
      end
      BK_MUL:  ld_mul = 1'b1;
      BK_DIV:  div_en = 1'b1;
      BK_FIN:  fin_load = !out_valid_r || out_bus.ready;
      default: pop_ready = 1'b0;
    endcase
  end

  // Products: gain times weight magnitude, recovery ratio times base
  assign sum_abs = (cmd_r.sum < 4'sd0) ? 2'(-cmd_r.sum) : cmd_r.sum[1:0];
  assign dmag    = DMAG_W'(cfg.prop_gain) * DMAG_W'(sum_abs);

  // One radix-4 restoring divide step by the active sensor count
  always_comb begin
    n1   = {2'b0, cmd_r.count};
    n2   = {n1[3:0], 1'b0};
    n3   = n1 + n2;
    part = {rem_r, quo_r[DMAG_W-1 -: 2]};
    if (part >= n3) begin
      digit     = 2'd3;
      part_left = part - n3;
    end else if (part >= n2) begin
      digit     = 2'd2;
      part_left = part - n2;
    end else if (part >= n1) begin
      digit     = 2'd1;
      part_left = part - n1;
    end else begin
      digit     = 2'd0;
      part_left = part;
    end
    rem_nxt = part_left[2:0];
    quo_nxt = {quo_r[DMAG_W-3:0], digit};
  end

  // Final speeds
  always_comb begin
    trk_left  = trunc_term(cfg.base_speed, quo_r, rem_r != 3'd0, !dneg_r);
    trk_right = trunc_term(cfg.base_speed, quo_r, rem_r != 3'd0, dneg_r);
    rec_up    = $signed({4'b0, cfg.base_speed}) + $signed({3'b0, prod_r[16:8]});
    rec_diff  = $signed({2'b0, cfg.base_speed, 8'b0}) - $signed({1'b0, prod_r});
    rec_mag   = -rec_diff;
    if (rec_diff < 18'sd0) begin
      rec_down = -$signed({2'b0, rec_mag[17:8]});
    end else begin
      rec_down = $signed({2'b0, rec_diff[17:8]});
    end
    case (cmd_r.mode)
      MODE_TRACK: begin
        spd_left  = trk_left;
        spd_right = trk_right;
      end
      MODE_RECOVER_LEFT: begin
        spd_left  = rec_up;
        spd_right = rec_down;
      end
      MODE_RECOVER_RIGHT: begin
        spd_left  = rec_down;
        spd_right = rec_up;
      end
      default: begin
        spd_left  = 12'sd0;
        spd_right = 12'sd0;
      end
    endcase
    case (cmd_r.mode)
      MODE_LOST_BASE: begin
        left_nxt  = '{mag: cfg.base_speed, rev: 1'b0};
        right_nxt = '{mag: cfg.base_speed, rev: 1'b0};
      end
      MODE_LOST_STRAIGHT: begin
        left_nxt  = '{mag: cfg.straight_speed, rev: 1'b0};
        right_nxt = '{mag: cfg.straight_speed, rev: 1'b0};
      end
      default: begin
        left_nxt  = encode_speed(spd_left, cfg.max_speed);
        right_nxt = encode_speed(spd_right, cfg.max_speed);
      end
    endcase
  end

  // Output register valid
  always_comb begin
    if (fin_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ld_cmd) begin
      cmd_r <= pop_cmd;
    end
    if (ld_mul) begin
      quo_r  <= dmag;
      rem_r  <= 3'd0;
      step_r <= '0;
      dneg_r <= (cmd_r.sum < 4'sd0);
      prod_r <= 17'(cfg.recovery_ratio_q8) * 17'(cfg.base_speed);
    end
    if (div_en) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + STEP_W'(1);
    end
    if (fin_load) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      mode_r  <= cmd_r.mode;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.left_magnitude  = left_r.mag;
  assign out_bus.left_reverse    = left_r.rev;
  assign out_bus.right_magnitude = right_r.mag;
  assign out_bus.right_reverse   = right_r.rev;
  assign out_bus.drive_mode      = mode_r;

endmodule

>>> hdl/line_follow_motor_controller_unit.sv
// Channel  | Role   | Handshake    | Payload
// in_bus   | sink   | valid/ready  | sensor_bits[4:0]
// out_bus  | source | valid/ready  | left/right magnitude[7:0], reverse, drive_mode[2:0]
// cfg_bus  | sink   | valid/ready  | index[2:0], data[8:0]
//
// In the back end a tracking beat goes through command pop, a product step,
// five radix-4 divide steps by the active sensor count and a finish step.
// Recovery and lost beats skip the divider, which sets the sustained rate.
// The front accepts a beat in any cycle the command queue has room, so input
// and output stall independently. Reset is synchronous; cfg_bus is always ready.
module line_follow_motor_controller_unit #(
  parameter int QUEUE_DEPTH = lfmc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lfmc_in_if.sink    in_bus,
  lfmc_out_if.source out_bus,
  lfmc_cfg_if.sink   cfg_bus
);
  import lfmc_pkg::*;

  cfg_t cfg_r;
  cmd_t push_cmd, pop_cmd;
  logic push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_bus.ready = 1'b1;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed        <= BASE_SPEED_RST;
      cfg_r.prop_gain         <= PROP_GAIN_RST;
      cfg_r.recovery_ratio_q8 <= RECOVERY_RATIO_RST;
      cfg_r.lost_limit        <= LOST_LIMIT_RST;
      cfg_r.straight_speed    <= STRAIGHT_SPEED_RST;
      cfg_r.max_speed         <= MAX_SPEED_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_BASE_SPEED:     cfg_r.base_speed        <= cfg_bus.data[7:0];
        REG_PROP_GAIN:      cfg_r.prop_gain         <= cfg_bus.data[7:0];
        REG_RECOVERY_RATIO: cfg_r.recovery_ratio_q8 <= cfg_bus.data;
        REG_LOST_LIMIT:     cfg_r.lost_limit        <= cfg_bus.data[5:0];
        REG_STRAIGHT_SPEED: cfg_r.straight_speed    <= cfg_bus.data[7:0];
        REG_MAX_SPEED:      cfg_r.max_speed         <= cfg_bus.data[7:0];
        default: ;
      endcase
    end
  end

  lfmc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lfmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lfmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_bus   (out_bus)
  );

endmodule

>>> hdl/lfmc_checker.sv
module lfmc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] left_magnitude,
  input logic       left_reverse,
  input logic [7:0] right_magnitude,
  input logic       right_reverse,
  input logic [2:0] drive_mode
);
  import lfmc_pkg::*;

  // Hold a stalled result beat: magnitudes and drive mode stay stable
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_magnitude)
      && $stable(right_magnitude) && $stable(drive_mode))
    else $error("result beat changed while stalled");

  // Lost modes drive both motors forward at one speed
  a_lost_forward: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (drive_mode == MODE_LOST_BASE || drive_mode == MODE_LOST_STRAIGHT)
      |-> !left_reverse && !right_reverse && left_magnitude == right_magnitude)
    else $error("lost mode with reverse or unequal speeds");

  // Reverse only with a nonzero magnitude
  a_reverse_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!left_reverse || left_magnitude != 8'd0)
      && (!right_reverse || right_magnitude != 8'd0))
    else $error("reverse flag with zero magnitude");

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind line_follow_motor_controller_unit lfmc_checker u_lfmc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .left_magnitude  (out_bus.left_magnitude),
  .left_reverse    (out_bus.left_reverse),
  .right_magnitude (out_bus.right_magnitude),
  .right_reverse   (out_bus.right_reverse),
  .drive_mode      (out_bus.drive_mode)
);

>>> test/line_follow_motor_controller_unit_test.sv
module line_follow_motor_controller_unit_test;
  import lfmc_pkg::*;

  localparam int TICK_TARGET     = 1120;
  localparam int PHASE_TICKS     = 120;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RUN_LIMIT       = 3_000_000;

  // Indexes past the register map; writes there must change nothing
  localparam logic [2:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_B = 3'd7;

  typedef struct packed {
    logic [7:0] lmag;
    logic       lrev;
    logic [7:0] rmag;
    logic       rrev;
    mode_t      mode;
  } motor_cmd_t;

  typedef struct packed {
    logic       is_write;
    logic [2:0] idx;
    logic [8:0] data;
    logic [4:0] bits;
    logic       pinned;
    motor_cmd_t want;
  } drive_row_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE
  } rx_style_t;

  logic clk;
  logic rst_n;

  lfmc_in_if  in_ch ();
  lfmc_out_if out_ch ();
  lfmc_cfg_if cfg_ch ();

  line_follow_motor_controller_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch),
    .cfg_bus(cfg_ch)
  );

  // Predictor state: register copy, edge memory and lost tick counter
  cfg_t       drive_cfg;
  logic       track_edge_left;
  logic       track_edge_right;
  logic [5:0] lost_ticks;

  motor_cmd_t expected_drives [$];
  drive_row_t directed_rows [$];

  int  fail_count;
  int  ticks_sent;
  int  results_seen;
  int  writes_done;
  int  settings_used;
  int  sat_hits;
  int  holds_done;
  int  mode_hits [5];
  bit  hold_off_req;
  bit  offering;
  bit  gapless;
  int  burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Clamp a signed speed to +/- lim, then split into magnitude and reverse
  function automatic motor_t split_speed(input int speed, input logic [7:0] lim);
    int     cap;
    int     s;
    motor_t m;
    cap = int'(lim);
    s = speed;
    if (s > cap) s = cap;
    if (s < -cap) s = -cap;
    m.rev = (s < 0);
    m.mag = 8'(s < 0 ? -s : s);
    return m;
  endfunction

  function automatic void apply_setting(input logic [2:0] idx, input logic [8:0] val);
    case (idx)
      REG_BASE_SPEED:     drive_cfg.base_speed = val[7:0];
      REG_PROP_GAIN:      drive_cfg.prop_gain = val[7:0];
      REG_RECOVERY_RATIO: drive_cfg.recovery_ratio_q8 = val;
      REG_LOST_LIMIT:     drive_cfg.lost_limit = val[5:0];
      REG_STRAIGHT_SPEED: drive_cfg.straight_speed = val[7:0];
      REG_MAX_SPEED:      drive_cfg.max_speed = val[7:0];
      default: ;
    endcase
  endfunction

  // Work out the motor command for one tick and advance the steering state
  function automatic motor_cmd_t predict_drive(input logic [4:0] bits);
    int         active;
    int         wsum;
    int         base;
    int         turn;
    int         lspeed;
    int         rspeed;
    int         k;
    motor_cmd_t cmd;
    motor_t     lm;
    motor_t     rm;
    cmd = '0;
    base = int'(drive_cfg.base_speed);
    active = 0;
    wsum = 0;
    lspeed = 0;
    rspeed = 0;
    if (bits != 5'd0) begin
      // bit4 far left weighs -2, bit0 far right +2
      for (k = 0; k < 5; k++) begin
        if (bits[k]) begin
          active++;
          wsum += 2 - k;
        end
      end
      lspeed = (base * active - int'(drive_cfg.prop_gain) * wsum) / active;
      rspeed = (base * active + int'(drive_cfg.prop_gain) * wsum) / active;
      lost_ticks = '0;
      track_edge_left = bits[4];
      track_edge_right = bits[0];
      cmd.mode = MODE_TRACK;
    end else if (track_edge_left || track_edge_right) begin
      // Turn back toward the remembered edge; left wins when both are set
      turn = int'(drive_cfg.recovery_ratio_q8) * base;
      if (track_edge_left) begin
        lspeed = (base * 256 + turn) / 256;
        rspeed = (base * 256 - turn) / 256;
        cmd.mode = MODE_RECOVER_LEFT;
      end else begin
        lspeed = (base * 256 - turn) / 256;
        rspeed = (base * 256 + turn) / 256;
        cmd.mode = MODE_RECOVER_RIGHT;
      end
    end else begin
      // Count lost ticks, saturating; no clamp on the forward speed
      if (lost_ticks < LOST_COUNT_MAX) lost_ticks++;
      else sat_hits++;
      if (lost_ticks >= drive_cfg.lost_limit) begin
        cmd.lmag = drive_cfg.straight_speed;
        cmd.rmag = drive_cfg.straight_speed;
        cmd.mode = MODE_LOST_STRAIGHT;
      end else begin
        cmd.lmag = drive_cfg.base_speed;
        cmd.rmag = drive_cfg.base_speed;
        cmd.mode = MODE_LOST_BASE;
      end
      return cmd;
    end
    lm = split_speed(lspeed, drive_cfg.max_speed);
    rm = split_speed(rspeed, drive_cfg.max_speed);
    cmd.lmag = lm.mag;
    cmd.lrev = lm.rev;
    cmd.rmag = rm.mag;
    cmd.rrev = rm.rev;
    return cmd;
  endfunction

  function automatic drive_row_t cfg_row(input logic [2:0] idx, input logic [8:0] val);
    drive_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.data = val;
    return r;
  endfunction

  function automatic drive_row_t tick_row(input logic [4:0] bits);
    drive_row_t r;
    r = '0;
    r.bits = bits;
    return r;
  endfunction

  function automatic drive_row_t tick_want(input logic [4:0] bits, input logic [7:0] lm,
                                           input logic lr, input logic [7:0] rm,
                                           input logic rr, input mode_t mode);
    drive_row_t r;
    r = tick_row(bits);
    r.pinned = 1'b1;
    r.want.lmag = lm;
    r.want.lrev = lr;
    r.want.rmag = rm;
    r.want.rrev = rr;
    r.want.mode = mode;
    return r;
  endfunction

  // Offer one sensor beat, queue its command, then idle between bursts unless gapless
  task automatic offer_item(input logic [4:0] bits, input bit pinned = 1'b0,
                            input motor_cmd_t pinned_cmd = '0);
    motor_cmd_t cmd;
    int         gap;
    in_ch.valid <= 1'b1;
    in_ch.sensor_bits <= bits;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    cmd = predict_drive(bits);
    expected_drives.push_back(pinned ? pinned_cmd : cmd);
    ticks_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !gapless) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every queued command has come back
  task automatic sender_rest();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_drives.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [8:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_setting(idx, val);
    writes_done++;
  endtask

  // Load a full register set: both extremes first, random after that; then write one unmapped index
  task automatic load_phase_settings(input int phase);
    logic [8:0] base_v;
    logic [8:0] gain_v;
    logic [8:0] ratio_v;
    logic [8:0] limit_v;
    logic [8:0] straight_v;
    logic [8:0] max_v;
    if (phase == 0) begin
      base_v = 9'h0FF;
      gain_v = 9'h0FF;
      ratio_v = 9'h1FF;
      limit_v = 9'd63;
      straight_v = 9'h0FF;
      max_v = 9'h0FF;
    end else if (phase == 1) begin
      base_v = '0;
      gain_v = '0;
      ratio_v = '0;
      limit_v = '0;
      straight_v = '0;
      max_v = '0;
    end else begin
      base_v = 9'($urandom_range(0, 511));
      gain_v = 9'($urandom_range(0, 511));
      ratio_v = 9'($urandom_range(0, 511));
      limit_v = ($urandom_range(0, 1) == 1) ? 9'($urandom_range(1, 8))
                                            : 9'($urandom_range(0, 511));
      straight_v = 9'($urandom_range(0, 511));
      max_v = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 40))
                                          : 9'($urandom_range(0, 511));
    end
    cfg_write(REG_BASE_SPEED, base_v);
    cfg_write(REG_PROP_GAIN, gain_v);
    cfg_write(REG_RECOVERY_RATIO, ratio_v);
    cfg_write(REG_LOST_LIMIT, limit_v);
    cfg_write(REG_STRAIGHT_SPEED, straight_v);
    cfg_write(REG_MAX_SPEED, max_v);
    cfg_write((phase % 2 == 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
              9'($urandom_range(0, 511)));
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Receiver: switch between streaming, coin-flip and sparse ready, plus long holds
  initial begin
    int        hold_left;
    int        style_left;
    rx_style_t style;
    hold_left = 0;
    style_left = 0;
    style = RX_STREAM;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        holds_done++;
        out_ch.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style = rx_style_t'($urandom_range(0, 2));
          style_left = $urandom_range(20, 120);
        end
        style_left--;
        case (style)
          RX_STREAM: out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
          default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each accepted result beat with the oldest queued command
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin : check_beat
      motor_cmd_t want;
      results_seen++;
      if (expected_drives.size() == 0) begin
        $error("result beat with no command queued: mode %0d", out_ch.drive_mode);
        fail_count++;
      end else begin
        want = expected_drives.pop_front();
        mode_hits[int'(want.mode)]++;
        if (out_ch.left_magnitude !== want.lmag) begin
          $error("left_magnitude: expected %0d, got %0d", want.lmag, out_ch.left_magnitude);
          fail_count++;
        end
        if (out_ch.left_reverse !== want.lrev) begin
          $error("left_reverse: expected %0d, got %0d", want.lrev, out_ch.left_reverse);
          fail_count++;
        end
        if (out_ch.right_magnitude !== want.rmag) begin
          $error("right_magnitude: expected %0d, got %0d", want.rmag, out_ch.right_magnitude);
          fail_count++;
        end
        if (out_ch.right_reverse !== want.rrev) begin
          $error("right_reverse: expected %0d, got %0d", want.rrev, out_ch.right_reverse);
          fail_count++;
        end
        if (out_ch.drive_mode !== want.mode) begin
          $error("drive_mode: expected %0d, got %0d", want.mode, out_ch.drive_mode);
          fail_count++;
        end
      end
    end
  end

  initial begin
    drive_row_t row;
    int         phase;
    int         phase_start;
    int         lead;
    int         run;
    bit         paused;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sensor_bits <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    drive_cfg.base_speed = BASE_SPEED_RST;
    drive_cfg.prop_gain = PROP_GAIN_RST;
    drive_cfg.recovery_ratio_q8 = RECOVERY_RATIO_RST;
    drive_cfg.lost_limit = LOST_LIMIT_RST;
    drive_cfg.straight_speed = STRAIGHT_SPEED_RST;
    drive_cfg.max_speed = MAX_SPEED_RST;
    track_edge_left = 1'b0;
    track_edge_right = 1'b0;
    lost_ticks = '0;
    burst_left = $urandom_range(1, 12);
    gapless = 1'b0;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset values, every mode, edge priority, clamps and masking
    directed_rows = '{
      tick_want(5'b00100, 8'd120, 1'b0, 8'd120, 1'b0, MODE_TRACK),
      tick_want(5'b00000, 8'd120, 1'b0, 8'd120, 1'b0, MODE_LOST_BASE),
      tick_want(5'b10000, 8'd180, 1'b0, 8'd60, 1'b0, MODE_TRACK),
      tick_want(5'b00000, 8'd216, 1'b0, 8'd23, 1'b0, MODE_RECOVER_LEFT),
      tick_want(5'b00001, 8'd60, 1'b0, 8'd180, 1'b0, MODE_TRACK),
      tick_want(5'b00000, 8'd23, 1'b0, 8'd216, 1'b0, MODE_RECOVER_RIGHT),
      tick_want(5'b10001, 8'd120, 1'b0, 8'd120, 1'b0, MODE_TRACK),
      tick_want(5'b00000, 8'd216, 1'b0, 8'd23, 1'b0, MODE_RECOVER_LEFT),
      tick_row(5'b11000),
      tick_row(5'b00011),
      tick_row(5'b01110),
      tick_row(5'b11111),
      cfg_row(REG_MAX_SPEED, 9'd0),
      tick_want(5'b11111, 8'd0, 1'b0, 8'd0, 1'b0, MODE_TRACK),
      cfg_row(REG_MAX_SPEED, 9'd255),
      cfg_row(REG_BASE_SPEED, 9'd255),
      cfg_row(REG_PROP_GAIN, 9'd255),
      tick_want(5'b10000, 8'd255, 1'b0, 8'd255, 1'b1, MODE_TRACK),
      cfg_row(REG_RECOVERY_RATIO, 9'h1FF),
      tick_want(5'b00000, 8'd255, 1'b0, 8'd254, 1'b1, MODE_RECOVER_LEFT),
      cfg_row(REG_LOST_LIMIT, 9'd0),
      cfg_row(REG_STRAIGHT_SPEED, 9'd255),
      tick_row(5'b01000),
      tick_want(5'b00000, 8'd255, 1'b0, 8'd255, 1'b0, MODE_LOST_STRAIGHT),
      cfg_row(REG_UNMAPPED_A, 9'h1FF),
      cfg_row(REG_UNMAPPED_B, 9'd0),
      cfg_row(REG_BASE_SPEED, 9'h100),
      cfg_row(REG_LOST_LIMIT, 9'd63),
      tick_want(5'b00000, 8'd0, 1'b0, 8'd0, 1'b0, MODE_LOST_BASE),
      tick_row(5'b00100),
      cfg_row(REG_RECOVERY_RATIO, 9'd256),
      cfg_row(REG_BASE_SPEED, 9'd200),
      tick_row(5'b00001),
      tick_row(5'b00000),
      tick_row(5'b11011)
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) begin
        sender_rest();
        cfg_write(row.idx, row.data);
        if (i + 1 == directed_rows.size() || !directed_rows[i + 1].is_write)
          cfg_ch.valid <= 1'b0;
      end else begin
        offer_item(row.bits, row.pinned, row.want);
      end
    end
    settings_used++;

    // Random phases: mostly line segments followed by runs off the line
    phase = 0;
    while (ticks_sent < TICK_TARGET) begin
      sender_rest();
      load_phase_settings(phase);
      gapless = (phase % 3 == 2);
      if (phase == 2) hold_off_req = 1'b1;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        if (phase == 3 && !paused && ticks_sent - phase_start >= PHASE_TICKS / 2) begin
          sender_rest();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) begin
          lead = $urandom_range(1, 3);
          repeat (lead - 1) offer_item(5'($urandom_range(1, 31)));
          // Last line tick often misses both edges so the lost counter runs
          if ($urandom_range(0, 1) == 1)
            offer_item({1'b0, 3'($urandom_range(1, 7)), 1'b0});
          else
            offer_item(5'($urandom_range(1, 31)));
          run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
          repeat (run) offer_item(5'd0);
        end else begin
          repeat ($urandom_range(1, 5)) offer_item(5'($urandom_range(0, 31)));
        end
      end
      phase++;
    end
    gapless = 1'b0;

    sender_rest();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d sensor ticks, %0d results back, under %0d register settings.",
             ticks_sent, results_seen, settings_used);
    $display("Modes: track %0d, recover L %0d, recover R %0d, lost %0d, straight %0d; %0d sat.",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4], sat_hits);
    $display("Register writes %0d, long receiver holds %0d.", writes_done, holds_done);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
